@@ src/jsr_pkg.sv @@
// ----------------------------------------------------------------------------
// jsr_pkg
// Shared constants, types and tables for the jittered sinc resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package jsr_pkg;

  // window geometry
  localparam int HALF_TAPS = 32;
  localparam int WIN_LEN   = 2 * HALF_TAPS;
  localparam int WIN_AW    = $clog2(WIN_LEN);
  localparam int JIT_AW    = $clog2(HALF_TAPS);
  localparam int CNT_W     = $clog2(WIN_LEN + 1);

  // word fields
  localparam int SAMPLE_W = 24;
  localparam int JITTER_W = 23;
  localparam int JIT_SHL  = 10;

  // q30 constants
  localparam longint ONE_Q30     = 64'sd1 << 30;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // angle and tap argument widths
  localparam int     ANG_W = 35;
  localparam longint X_MAX = HALF_TAPS * PI_Q30 + (64'sd1 << 32);
  localparam int     X_W   = $clog2(X_MAX) + 1;
  localparam int     DEN_W = X_W - 1;

  // divider, sine and accumulator widths
  localparam int QW        = 32;
  localparam int MAG_W     = 31;
  localparam int TAP_W     = 32;
  localparam int PROD_W    = SAMPLE_W + TAP_W;
  localparam int PROD_SHR  = 20;
  localparam int TERM_W    = PROD_W - PROD_SHR;
  localparam int ACC_W     = TERM_W + WIN_AW;
  localparam int RND_SHR   = 10;
  localparam int SIN_STEPS = 6;
  localparam int STEP_W    = 3;
  localparam int MAGIC_W   = QW + 1;
  localparam int RCP_W     = QW + MAGIC_W;

  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [JITTER_W-1:0] jitter_t;

  // reciprocal multipliers of the horner divisors 156, 110, 72, 42, 20 and 6,
  // exact floor quotients for any 32 bit dividend
  function automatic logic [MAGIC_W-1:0] sin_magic(input logic [STEP_W-1:0] step);
    logic [MAGIC_W-1:0] mg;
    unique case (step)
      3'd0:    mg = MAGIC_W'((64'd1 << 40) / 64'd156 + 64'd1);
      3'd1:    mg = MAGIC_W'((64'd1 << 39) / 64'd110 + 64'd1);
      3'd2:    mg = MAGIC_W'((64'd1 << 39) / 64'd72 + 64'd1);
      3'd3:    mg = MAGIC_W'((64'd1 << 38) / 64'd42 + 64'd1);
      3'd4:    mg = MAGIC_W'((64'd1 << 37) / 64'd20 + 64'd1);
      default: mg = MAGIC_W'((64'd1 << 35) / 64'd6 + 64'd1);
    endcase
    return mg;
  endfunction

  // right shift that goes with each reciprocal multiplier
  function automatic logic [6:0] sin_shift(input logic [STEP_W-1:0] step);
    logic [6:0] s;
    unique case (step)
      3'd0:    s = 7'd40;
      3'd1:    s = 7'd39;
      3'd2:    s = 7'd39;
      3'd3:    s = 7'd38;
      3'd4:    s = 7'd37;
      default: s = 7'd35;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] r0;
    logic [QW-1:0]    bits;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic              s_rd;
    logic [WIN_AW-1:0] tap;
    logic              j_rd;
  } win_rd_t;

endpackage

`default_nettype wire

@@ src/jsr_in_if.sv @@
// ----------------------------------------------------------------------------
// jsr_in_if
// Input channel: one word carries an op, a sample and a jitter phase.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsr_in_if;
  logic             valid;
  logic             ready;
  logic             op;
  jsr_pkg::sample_t sample;
  jsr_pkg::jitter_t jitter;

  modport source (output valid, output op, output sample, output jitter, input ready);
  modport sink   (input valid, input op, input sample, input jitter, output ready);
endinterface

`default_nettype wire

@@ src/jsr_out_if.sv @@
// ----------------------------------------------------------------------------
// jsr_out_if
// Output channel: one word carries an interpolated value and a clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsr_out_if;
  logic             valid;
  logic             ready;
  jsr_pkg::sample_t value;
  logic             clipped;

  modport source (output valid, output value, output clipped, input ready);
  modport sink   (input valid, input value, input clipped, output ready);
endinterface

`default_nettype wire

@@ src/jsr_window.sv @@
// ----------------------------------------------------------------------------
// jsr_window
// Circular sample window and jitter delay memories with registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module jsr_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              op,
  input  jsr_pkg::sample_t  sample,
  input  jsr_pkg::jitter_t  jitter,
  output logic              trigger,
  input  jsr_pkg::win_rd_t  rd,
  output jsr_pkg::sample_t  smp_data,
  output jsr_pkg::jitter_t  jit_data
);

  jsr_pkg::sample_t smem [jsr_pkg::WIN_LEN];
  jsr_pkg::jitter_t jmem [jsr_pkg::HALF_TAPS];

  logic [jsr_pkg::WIN_AW-1:0]    wp;
  logic [jsr_pkg::JIT_AW-1:0]    jp;
  logic [jsr_pkg::CNT_W-1:0]     cnt;
  logic [jsr_pkg::HALF_TAPS-1:0] pv;
  logic [jsr_pkg::HALF_TAPS-1:0] pv_next;
  jsr_pkg::sample_t              s_q;
  logic                          s_vld;

  logic [jsr_pkg::WIN_AW:0]   addr_sum;
  logic [jsr_pkg::WIN_AW-1:0] raddr;
  logic [jsr_pkg::CNT_W:0]    age_sum;
  logic                       tap_vld;

  // pending flags shift with every word; a data word at the head triggers
  assign pv_next = {~op, pv[jsr_pkg::HALF_TAPS-1:1]};
  assign trigger = pv_next[0];

  // tap k sits k places after the oldest entry
  always_comb begin
    addr_sum = {1'b0, wp} + {1'b0, rd.tap};
    if (addr_sum >= (jsr_pkg::WIN_AW+1)'(jsr_pkg::WIN_LEN)) begin
      addr_sum = addr_sum - (jsr_pkg::WIN_AW+1)'(jsr_pkg::WIN_LEN);
    end
    raddr   = addr_sum[jsr_pkg::WIN_AW-1:0];
    age_sum = (jsr_pkg::CNT_W+1)'(rd.tap) + {1'b0, cnt};
    tap_vld = age_sum >= (jsr_pkg::CNT_W+1)'(jsr_pkg::WIN_LEN);
  end

  // pointers, push count and pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      jp  <= '0;
      cnt <= '0;
      pv  <= '0;
    end else if (push) begin
      wp  <= (wp == jsr_pkg::WIN_AW'(jsr_pkg::WIN_LEN - 1)) ? '0 : wp + 1'b1;
      jp  <= (jp == jsr_pkg::JIT_AW'(jsr_pkg::HALF_TAPS - 1)) ? '0 : jp + 1'b1;
      if (cnt != jsr_pkg::CNT_W'(jsr_pkg::WIN_LEN)) begin
        cnt <= cnt + 1'b1;
      end
      pv  <= pv_next;
    end
  end

  // sample memory; entries older than the push count read as zero
  always_ff @(posedge clk) begin
    if (push) begin
      smem[wp] <= op ? '0 : sample;
    end
    if (rd.s_rd) begin
      s_q   <= smem[raddr];
      s_vld <= tap_vld;
    end
  end

  // jitter memory; the slot after the newest holds the head word
  always_ff @(posedge clk) begin
    if (push && !op) begin
      jmem[jp] <= jitter;
    end
    if (rd.j_rd) begin
      jit_data <= jmem[jp];
    end
  end

  assign smp_data = s_vld ? s_q : '0;

endmodule

`default_nettype wire

@@ src/jsr_div.sv @@
// ----------------------------------------------------------------------------
// jsr_div
// Serial restoring divider, one quotient bit per cycle, 32 bits per divide.
// ----------------------------------------------------------------------------
`default_nettype none

module jsr_div (
  input  logic              clk,
  input  logic              rst,
  input  jsr_pkg::div_req_t req,
  output jsr_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(jsr_pkg::QW);

  logic                      busy;
  logic                      done;
  logic [CW-1:0]             cnt;
  logic [jsr_pkg::DEN_W-1:0] rem;
  logic [jsr_pkg::DEN_W-1:0] den;
  logic [jsr_pkg::QW-1:0]    sh;
  logic [jsr_pkg::QW-1:0]    quo;

  logic [jsr_pkg::DEN_W:0] trial;
  logic [jsr_pkg::DEN_W:0] diff;
  logic                    ge;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, sh[jsr_pkg::QW-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(jsr_pkg::QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.r0;
      den <= req.den;
      sh  <= req.bits;
    end else if (busy) begin
      rem <= ge ? diff[jsr_pkg::DEN_W-1:0] : trial[jsr_pkg::DEN_W-1:0];
      quo <= {quo[jsr_pkg::QW-2:0], ge};
      sh  <= sh << 1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.q    = quo;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) busy |-> rem < den)
    else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ src/jsr_core.sv @@
// ----------------------------------------------------------------------------
// jsr_core
// Sequencer: sine of the jitter, tap by tap division and multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module jsr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              idle,
  output jsr_pkg::win_rd_t  wrd,
  input  jsr_pkg::jitter_t  jit_data,
  input  jsr_pkg::sample_t  smp_data,
  output jsr_pkg::div_req_t dreq,
  input  jsr_pkg::div_rsp_t drsp,
  jsr_out_if.source         out_ch
);

  localparam int ANG_W = jsr_pkg::ANG_W;
  localparam int X_W   = jsr_pkg::X_W;
  localparam int DEN_W = jsr_pkg::DEN_W;
  localparam int MAG_W = jsr_pkg::MAG_W;
  localparam int TAP_W = jsr_pkg::TAP_W;
  localparam int QW    = jsr_pkg::QW;
  localparam int V_W   = jsr_pkg::ACC_W - jsr_pkg::RND_SHR;

  localparam logic signed [ANG_W-1:0] PI_A    = ANG_W'(jsr_pkg::PI_Q30);
  localparam logic signed [ANG_W-1:0] HPI_A   = ANG_W'(jsr_pkg::HALF_PI_Q30);
  localparam logic signed [X_W-1:0]   PI_X    = X_W'(jsr_pkg::PI_Q30);
  localparam logic signed [X_W-1:0]   X_START = X_W'(jsr_pkg::HALF_TAPS * jsr_pkg::PI_Q30);
  localparam logic signed [X_W-1:0]   X_ONE   = X_W'(1);
  localparam logic signed [TAP_W-1:0] TAP_ONE = TAP_W'(jsr_pkg::ONE_Q30);
  localparam logic signed [V_W-1:0]   V_MAX   = V_W'(jsr_pkg::OUT_MAX);
  localparam logic signed [V_W-1:0]   V_MIN   = V_W'(jsr_pkg::OUT_MIN);
  localparam logic [jsr_pkg::STEP_W-1:0] LAST_STEP = jsr_pkg::STEP_W'(jsr_pkg::SIN_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_JRD, S_JIT, S_MUL, S_MRES, S_RCP, S_TAP, S_TDIV, S_MAC, S_ACC, S_OUT
  } state_t;

  state_t                             state;
  logic [jsr_pkg::STEP_W-1:0]         step;
  logic [jsr_pkg::WIN_AW-1:0]         k;
  logic [MAG_W-1:0]                   m;
  logic                               sneg;
  logic [QW-1:0]                      a2;
  logic [MAG_W-1:0]                   t;
  logic [MAG_W-1:0]                   sn_abs;
  logic                               sn_neg;
  logic signed [X_W-1:0]              x;
  logic                               tneg;
  logic signed [TAP_W-1:0]            tap;
  logic signed [jsr_pkg::PROD_W-1:0]  prod;
  logic signed [jsr_pkg::ACC_W-1:0]   acc;
  logic [QW+MAG_W-1:0]                mul_p;
  logic [jsr_pkg::RCP_W-1:0]          rcp_p;
  logic                               out_valid;
  jsr_pkg::sample_t                   out_value;
  logic                               out_clipped;

  logic signed [ANG_W-1:0]            j30;
  logic signed [ANG_W-1:0]            a_red;
  logic [ANG_W-1:0]                   a_abs;
  logic signed [X_W-1:0]              x_init;
  logic [QW-1:0]                      opa;
  logic [MAG_W-1:0]                   opb;
  logic                               x_neg;
  logic [X_W-1:0]                     x_abs;
  logic [DEN_W-1:0]                   den;
  logic                               near_zero;
  logic                               sat;
  logic                               tneg_now;
  logic [QW-1:0]                      qc;
  logic [QW-1:0]                      rcp_q;
  logic [QW:0]                        t_calc;
  logic signed [jsr_pkg::TERM_W-1:0]  term;
  logic signed [jsr_pkg::ACC_W-1:0]   rnd;
  logic signed [V_W-1:0]              v;

  // jitter to q30, folded into [-pi/2, pi/2]
  always_comb begin
    j30 = ANG_W'(jit_data) <<< jsr_pkg::JIT_SHL;
    if (j30 > HPI_A) begin
      a_red = PI_A - j30;
    end else if (j30 < -HPI_A) begin
      a_red = -PI_A - j30;
    end else begin
      a_red = j30;
    end
    a_abs  = a_red[ANG_W-1] ? ANG_W'(-a_red) : a_red;
    x_init = X_W'(j30) - X_START;
  end

  // shared multiplier operands for the horner steps
  always_comb begin
    if (step == '0 || step == LAST_STEP) begin
      opa = QW'(m);
    end else begin
      opa = a2;
    end
    opb = (step == '0) ? m : t;
  end

  // tap argument checks and horner quotient
  always_comb begin
    x_neg     = x[X_W-1];
    x_abs     = x_neg ? X_W'(-x) : x;
    den       = x_abs[DEN_W-1:0];
    near_zero = (x >= -X_ONE) && (x <= X_ONE);
    sat       = (DEN_W+1)'(sn_abs) >= {den, 1'b0};
    tneg_now  = sn_neg ^ x_neg ^ k[0];
    qc        = (drsp.q > QW'(jsr_pkg::ONE_Q30)) ? QW'(jsr_pkg::ONE_Q30) : drsp.q;
    rcp_q     = QW'(rcp_p >> jsr_pkg::sin_shift(step));
    t_calc    = (QW+1)'(jsr_pkg::ONE_Q30) - {1'b0, rcp_q};
  end

  // divider requests, taps only
  always_comb begin
    dreq.start = 1'b0;
    dreq.r0    = '0;
    dreq.bits  = '0;
    dreq.den   = '0;
    if (state == S_TAP) begin
      dreq.start = !near_zero && !sat;
      dreq.r0    = DEN_W'(sn_abs[MAG_W-1:2]);
      dreq.bits  = {sn_abs[1:0], 30'd0};
      dreq.den   = den;
    end
  end

  // memory reads
  always_comb begin
    wrd.j_rd = (state == S_JRD);
    wrd.s_rd = (state == S_TAP);
    wrd.tap  = k;
  end

  // scaled product term, and the accumulator rounded for output
  always_comb begin
    term = prod[jsr_pkg::PROD_W-1:jsr_pkg::PROD_SHR];
    rnd  = acc + jsr_pkg::ACC_W'(512);
    v    = rnd[jsr_pkg::ACC_W-1:jsr_pkg::RND_SHR];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      k         <= '0;
    end else begin
      if (out_ch.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_JRD;
          end
        end
        S_JRD: begin
          state <= S_JIT;
        end
        S_JIT: begin
          m     <= a_abs[MAG_W-1:0];
          sneg  <= a_red[ANG_W-1];
          x     <= x_init;
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          mul_p <= opa * opb;
          state <= S_MRES;
        end
        S_MRES: begin
          if (step == '0) begin
            a2 <= mul_p[61:30];
          end
          if (step == LAST_STEP) begin
            sn_abs <= mul_p[60:30];
            sn_neg <= sneg && (mul_p[60:30] != '0);
            k      <= '0;
            acc    <= '0;
            state  <= S_TAP;
          end else begin
            rcp_p <= mul_p[61:30] * jsr_pkg::sin_magic(step);
            state <= S_RCP;
          end
        end
        S_RCP: begin
          t     <= t_calc[MAG_W-1:0];
          step  <= step + 1'b1;
          state <= S_MUL;
        end
        S_TAP: begin
          tneg <= tneg_now;
          if (near_zero) begin
            tap   <= TAP_ONE;
            state <= S_MAC;
          end else if (sat) begin
            tap   <= tneg_now ? -TAP_ONE : TAP_ONE;
            state <= S_MAC;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (drsp.done) begin
            tap   <= tneg ? -$signed(qc) : $signed(qc);
            state <= S_MAC;
          end
        end
        S_MAC: begin
          prod  <= smp_data * tap;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + jsr_pkg::ACC_W'(term);
          x   <= x + PI_X;
          k   <= k + 1'b1;
          if (k == jsr_pkg::WIN_AW'(jsr_pkg::WIN_LEN - 1)) begin
            state <= S_OUT;
          end else begin
            state <= S_TAP;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            if (v > V_MAX) begin
              out_value   <= jsr_pkg::SAMPLE_W'(V_MAX);
              out_clipped <= 1'b1;
            end else if (v < V_MIN) begin
              out_value   <= jsr_pkg::SAMPLE_W'(V_MIN);
              out_clipped <= 1'b1;
            end else begin
              out_value   <= v[jsr_pkg::SAMPLE_W-1:0];
              out_clipped <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle           = (state == S_IDLE);
  assign out_ch.valid   = out_valid;
  assign out_ch.value   = out_value;
  assign out_ch.clipped = out_clipped;

`ifndef SYNTHESIS
  a_tap_mag: assert property (@(posedge clk) disable iff (rst)
      (state == S_MAC) |-> (tap <= TAP_ONE && tap >= -TAP_ONE))
    else $error("tap magnitude above one");
  a_div_free: assert property (@(posedge clk) disable iff (rst) dreq.start |-> !drsp.busy)
    else $error("divide requested while divider busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> (state == S_IDLE))
    else $error("new result started while sequencer busy");
`endif

endmodule

`default_nettype wire

@@ src/jittered_sinc_resampler.sv @@
// ----------------------------------------------------------------------------
// jittered_sinc_resampler
// Streaming sinc fractional-delay interpolator with per-sample jitter.
// ----------------------------------------------------------------------------
// Every accepted word pushes one Q1.23 sample (zero for a flush) into a
// 64-entry circular window memory, and a data word also stores its jitter.
// When a data word reaches the window centre, 31 pushes later, the block
// computes sin(jitter) and the 64 sinc taps and returns one saturated word.
// A word that causes no result leaves the block free for the next word. A
// word that causes a result stalls the input side while the sine takes six
// horner steps of multiply and reciprocal multiply and each tap is a divide
// on the shared serial divider, which yields one quotient bit a cycle (no
// divide when the tap is exactly one or saturated). The input is taken again
// as soon as the sum is loaded into the output register, even while that
// word waits for the sink. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module jittered_sinc_resampler (
  input  logic      clk,
  input  logic      rst,
  jsr_in_if.sink    in_ch,
  jsr_out_if.source out_ch
);

  logic              push;
  logic              trigger;
  logic              idle;
  jsr_pkg::win_rd_t  wrd;
  jsr_pkg::sample_t  smp_data;
  jsr_pkg::jitter_t  jit_data;
  jsr_pkg::div_req_t dreq;
  jsr_pkg::div_rsp_t drsp;

  // accept a word whenever the sequencer is free
  assign in_ch.ready = idle;
  assign push        = in_ch.valid && idle;

  jsr_window u_window (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .op       (in_ch.op),
    .sample   (in_ch.sample),
    .jitter   (in_ch.jitter),
    .trigger  (trigger),
    .rd       (wrd),
    .smp_data (smp_data),
    .jit_data (jit_data)
  );

  jsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  jsr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (push && trigger),
    .idle     (idle),
    .wrd      (wrd),
    .jit_data (jit_data),
    .smp_data (smp_data),
    .dreq     (dreq),
    .drsp     (drsp),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
